@@ rtl/gamepad_motor_command_mapper_core_assert.svh @@
// Assertion macros for the gamepad motor command mapper
`ifndef GAMEPAD_MOTOR_COMMAND_MAPPER_CORE_ASSERT_SVH
`define GAMEPAD_MOTOR_COMMAND_MAPPER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define GMCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmcm assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define GMCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmcm assertion failed");

`endif

@@ rtl/gmcm_pkg.sv @@
// Constants and helper functions for the gamepad motor command mapper
package gmcm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_GAIN     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_DEADBAND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEW_GAP       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEW_STEP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FLYWHEEL_TOP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDER_TIMEOUT = 3'd5;

  localparam logic [6:0]  RST_DRIVE_GAIN     = 7'd63;
  localparam logic [6:0]  RST_DRIVE_DEADBAND = 7'd25;
  localparam logic [6:0]  RST_SLEW_GAP       = 7'd20;
  localparam logic [6:0]  RST_SLEW_STEP      = 7'd10;
  localparam logic [6:0]  RST_FLYWHEEL_TOP   = 7'd90;
  localparam logic [15:0] RST_FEEDER_TIMEOUT = 16'd10000;

  // intake mode codes; the wrap code is transient and never stored
  localparam logic [1:0] INTAKE_OFF  = 2'd0;
  localparam logic [1:0] INTAKE_FWD  = 2'd1;
  localparam logic [1:0] INTAKE_WRAP = 2'd2;
  localparam logic [1:0] INTAKE_REV  = 2'd3;

  localparam logic signed [7:0] INTAKE_FWD_DRIVE = 8'sd80;
  localparam logic signed [7:0] INTAKE_REV_DRIVE = -8'sd90;
  localparam logic [6:0]        FEEDER_DRIVE     = 7'd90;
  localparam logic signed [7:0] ARM_UP_DRIVE     = 8'sd100;
  localparam logic signed [7:0] ARM_DOWN_DRIVE   = -8'sd100;

  // floor(x / 100) == (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic signed [9:0] CMD_MAX = 10'sd127;
  localparam logic signed [9:0] CMD_MIN = -10'sd127;

  typedef logic [14:0] gain_prod_t;

  function automatic logic [6:0] scale_mag(input gain_prod_t gp);
    logic [27:0] full;
    logic [8:0]  quo;
    full = 28'(gp) * 28'(RECIP_100);
    quo  = full[RECIP_SHIFT+8:RECIP_SHIFT];
    scale_mag = (quo > 9'd127) ? 7'd127 : quo[6:0];
  endfunction

  function automatic logic signed [7:0] slew_cmd(
    input logic [6:0]        mag,
    input logic              neg,
    input logic signed [7:0] cmd,
    input logic [6:0]        db,
    input logic [6:0]        gap,
    input logic [6:0]        step
  );
    logic signed [9:0] tgt;
    logic signed [9:0] cur;
    logic signed [9:0] diff;
    logic signed [9:0] gap_s;
    logic signed [9:0] up;
    logic signed [9:0] dn;
    tgt   = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
    cur   = {{2{cmd[7]}}, cmd};
    diff  = tgt - cur;
    gap_s = $signed({3'b000, gap});
    up    = cur + $signed({3'b000, step});
    dn    = cur - $signed({3'b000, step});
    if (mag <= db) begin
      slew_cmd = 8'sd0;
    end else if (diff > gap_s && !neg) begin
      slew_cmd = (up > CMD_MAX) ? 8'sd127 : up[7:0];
    end else if (diff < -gap_s && neg) begin
      slew_cmd = (dn < CMD_MIN) ? -8'sd127 : dn[7:0];
    end else begin
      slew_cmd = tgt[7:0];
    end
  endfunction

endpackage

@@ rtl/gamepad_motor_command_mapper_core.sv @@
// Gamepad motor command mapper: input register, tick logic, result register
// Structure: two register stages, the input register and the result register.
// Throughput: one word per cycle while out_stall does not hold the result; the input register multiplies stick by gain,
// the tick logic scales by 1/100, slews and steps the toggles before the result register.
// Reset: synchronous rst restores the config registers and tick state to their reset values
// and empties both stages; the config port is always ready.
`include "gamepad_motor_command_mapper_core_assert.svh"

module gamepad_motor_command_mapper_core
  import gmcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [7:0]      stick_a,
  input  logic signed [7:0]      stick_b,
  input  logic                   reverse_button,
  input  logic                   fly_button_one,
  input  logic                   fly_button_two,
  input  logic                   intake_fwd_button,
  input  logic                   intake_rev_button,
  input  logic                   feeder_button,
  input  logic                   arm_up_button,
  input  logic                   arm_down_button,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [7:0]      right_drive,
  output logic signed [7:0]      left_drive,
  output logic [6:0]             flywheel_pos,
  output logic signed [7:0]      flywheel_neg,
  output logic signed [7:0]      intake_drive,
  output logic [6:0]             feeder_drive,
  output logic signed [7:0]      arm_drive
);

  logic [6:0]  drive_gain_percent;
  logic [6:0]  drive_deadband;
  logic [6:0]  slew_gap;
  logic [6:0]  slew_step;
  logic [6:0]  flywheel_top;
  logic [15:0] feeder_timeout;

  logic        s1_valid;
  gain_prod_t  s1_prod_a;
  gain_prod_t  s1_prod_b;
  logic        s1_neg_a;
  logic        s1_neg_b;
  logic        s1_rev;
  logic        s1_fly1;
  logic        s1_fly2;
  logic        s1_in_f;
  logic        s1_in_r;
  logic        s1_fe;
  logic        s1_arm_u;
  logic        s1_arm_d;

  logic              reverse_mode;
  logic              reverse_latch;
  logic signed [7:0] right_cmd;
  logic signed [7:0] left_cmd;
  logic              fly_on;
  logic              fly_latch;
  logic [6:0]        fly_speed;
  logic [1:0]        intake_mode;
  logic              intake_latch;
  logic              feeder_on;
  logic              feeder_latch;
  logic [15:0]       feeder_ticks;

  logic              in_fire;
  logic              s1_fire;
  logic [7:0]        mag_a;
  logic [7:0]        mag_b;

  logic              reverse_mode_next;
  logic [6:0]        scl_a;
  logic [6:0]        scl_b;
  logic signed [7:0] right_cmd_next;
  logic signed [7:0] left_cmd_next;
  logic              fly_on_next;
  logic              fly_latch_next;
  logic [6:0]        fly_speed_next;
  logic [1:0]        intake_step;
  logic [1:0]        intake_mode_next;
  logic              feeder_tgl;
  logic [15:0]       feeder_ticks_next;
  logic              feeder_on_next;
  logic signed [7:0] intake_v;
  logic signed [7:0] arm_v;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_fire   = in_valid && !in_stall;

  assign mag_a = stick_a[7] ? 8'(-stick_a) : 8'(stick_a);
  assign mag_b = stick_b[7] ? 8'(-stick_b) : 8'(stick_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain_percent <= RST_DRIVE_GAIN;
      drive_deadband     <= RST_DRIVE_DEADBAND;
      slew_gap           <= RST_SLEW_GAP;
      slew_step          <= RST_SLEW_STEP;
      flywheel_top       <= RST_FLYWHEEL_TOP;
      feeder_timeout     <= RST_FEEDER_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_GAIN:     drive_gain_percent <= cfg_data[6:0];
        REG_DRIVE_DEADBAND: drive_deadband     <= cfg_data[6:0];
        REG_SLEW_GAP:       slew_gap           <= cfg_data[6:0];
        REG_SLEW_STEP:      slew_step          <= cfg_data[6:0];
        REG_FLYWHEEL_TOP:   flywheel_top       <= cfg_data[6:0];
        REG_FEEDER_TIMEOUT: feeder_timeout     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input stage: sign and |stick| * gain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_prod_a <= 15'(mag_a) * 15'(drive_gain_percent);
      s1_prod_b <= 15'(mag_b) * 15'(drive_gain_percent);
      s1_neg_a  <= stick_a[7];
      s1_neg_b  <= stick_b[7];
      s1_rev    <= reverse_button;
      s1_fly1   <= fly_button_one;
      s1_fly2   <= fly_button_two;
      s1_in_f   <= intake_fwd_button;
      s1_in_r   <= intake_rev_button;
      s1_fe     <= feeder_button;
      s1_arm_u  <= arm_up_button;
      s1_arm_d  <= arm_down_button;
    end
  end

  // tick logic
  always_comb begin
    reverse_mode_next = (s1_rev && !reverse_latch) ? !reverse_mode : reverse_mode;
    scl_a = scale_mag(s1_prod_a);
    scl_b = scale_mag(s1_prod_b);
    if (!reverse_mode_next) begin
      left_cmd_next  = slew_cmd(scl_a, s1_neg_a, left_cmd,
                                drive_deadband, slew_gap, slew_step);
      right_cmd_next = slew_cmd(scl_b, s1_neg_b, right_cmd,
                                drive_deadband, slew_gap, slew_step);
    end else begin
      right_cmd_next = slew_cmd(scl_a, !s1_neg_a, right_cmd,
                                drive_deadband, slew_gap, slew_step);
      left_cmd_next  = slew_cmd(scl_b, !s1_neg_b, left_cmd,
                                drive_deadband, slew_gap, slew_step);
    end

    fly_on_next    = (s1_fly1 && s1_fly2 && !fly_latch) ? !fly_on : fly_on;
    fly_latch_next = (s1_fly1 && s1_fly2) ? 1'b1
                   : (!s1_fly1 && !s1_fly2) ? 1'b0 : fly_latch;
    if (fly_on_next && fly_speed < flywheel_top) begin
      fly_speed_next = fly_speed + 7'd1;
    end else if (!fly_on_next && fly_speed != 7'd0) begin
      fly_speed_next = fly_speed - 7'd1;
    end else begin
      fly_speed_next = fly_speed;
    end

    if (s1_in_f && !intake_latch) begin
      intake_step = intake_mode + 2'd1;
    end else if (s1_in_r && !intake_latch) begin
      intake_step = intake_mode - 2'd1;
    end else begin
      intake_step = intake_mode;
    end
    intake_mode_next = (intake_step == INTAKE_WRAP) ? INTAKE_OFF : intake_step;
    case (intake_mode_next)
      INTAKE_FWD: intake_v = INTAKE_FWD_DRIVE;
      INTAKE_REV: intake_v = INTAKE_REV_DRIVE;
      default:    intake_v = 8'sd0;
    endcase

    feeder_tgl        = (s1_fe && !feeder_latch) ? !feeder_on : feeder_on;
    feeder_ticks_next = feeder_tgl ? feeder_ticks + 16'd1 : 16'd0;
    feeder_on_next    = feeder_tgl && (feeder_ticks_next != feeder_timeout);

    arm_v = s1_arm_u ? ARM_UP_DRIVE : (s1_arm_d ? ARM_DOWN_DRIVE : 8'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_mode  <= 1'b1;
      reverse_latch <= 1'b0;
      right_cmd     <= 8'sd0;
      left_cmd      <= 8'sd0;
      fly_on        <= 1'b0;
      fly_latch     <= 1'b0;
      fly_speed     <= 7'd0;
      intake_mode   <= INTAKE_OFF;
      intake_latch  <= 1'b0;
      feeder_on     <= 1'b0;
      feeder_latch  <= 1'b0;
      feeder_ticks  <= 16'd0;
    end else if (s1_fire) begin
      reverse_mode  <= reverse_mode_next;
      reverse_latch <= s1_rev;
      right_cmd     <= right_cmd_next;
      left_cmd      <= left_cmd_next;
      fly_on        <= fly_on_next;
      fly_latch     <= fly_latch_next;
      fly_speed     <= fly_speed_next;
      intake_mode   <= intake_mode_next;
      intake_latch  <= s1_in_f || s1_in_r;
      feeder_on     <= feeder_on_next;
      feeder_latch  <= s1_fe;
      feeder_ticks  <= feeder_ticks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      right_drive  <= right_cmd_next;
      left_drive   <= left_cmd_next;
      flywheel_pos <= fly_speed_next;
      flywheel_neg <= -$signed({1'b0, fly_speed_next});
      intake_drive <= intake_v;
      feeder_drive <= feeder_on_next ? FEEDER_DRIVE : 7'd0;
      arm_drive    <= arm_v;
    end
  end

  `GMCM_ASSERT_NEXT(a_state_holds, !s1_fire, $stable(fly_speed) && $stable(feeder_ticks))
  `GMCM_ASSERT_NEXT(a_fire_fills_out, s1_fire, out_valid)
  `GMCM_ASSERT_NEXT(a_fly_unit_step, s1_fire, (fly_speed == $past(fly_speed) + 7'd1) || (fly_speed == $past(fly_speed) - 7'd1) || (fly_speed == $past(fly_speed)))
  `GMCM_ASSERT_NOW(a_intake_no_wrap, s1_valid, intake_mode != INTAKE_WRAP)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for gamepad_motor_command_mapper_core: driver, predictor and scoreboard
module testbench
  import gmcm_pkg::*;
();

  localparam int LIMIT = 1000000;

  localparam logic [7:0] B_REV    = 8'h01;
  localparam logic [7:0] B_FLY1   = 8'h02;
  localparam logic [7:0] B_FLY2   = 8'h04;
  localparam logic [7:0] B_IN_FWD = 8'h08;
  localparam logic [7:0] B_IN_REV = 8'h10;
  localparam logic [7:0] B_FEED   = 8'h20;
  localparam logic [7:0] B_ARM_UP = 8'h40;
  localparam logic [7:0] B_ARM_DN = 8'h80;

  typedef struct packed {
    logic signed [7:0] sa;
    logic signed [7:0] sb;
    logic              arm_dn;
    logic              arm_up;
    logic              feed;
    logic              in_rev;
    logic              in_fwd;
    logic              fly2;
    logic              fly1;
    logic              rev;
  } tick_t;

  typedef struct packed {
    logic signed [7:0] right;
    logic signed [7:0] left;
    logic [6:0]        fly_pos;
    logic signed [7:0] fly_neg;
    logic signed [7:0] intake;
    logic [6:0]        feeder;
    logic signed [7:0] arm;
  } cmd_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [7:0]      stick_a = '0;
  logic signed [7:0]      stick_b = '0;
  logic                   reverse_button = 1'b0;
  logic                   fly_button_one = 1'b0;
  logic                   fly_button_two = 1'b0;
  logic                   intake_fwd_button = 1'b0;
  logic                   intake_rev_button = 1'b0;
  logic                   feeder_button = 1'b0;
  logic                   arm_up_button = 1'b0;
  logic                   arm_down_button = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [7:0]      right_drive;
  logic signed [7:0]      left_drive;
  logic [6:0]             flywheel_pos;
  logic signed [7:0]      flywheel_neg;
  logic signed [7:0]      intake_drive;
  logic [6:0]             feeder_drive;
  logic signed [7:0]      arm_drive;

  gamepad_motor_command_mapper_core DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // mapper registers and state
  logic [6:0]  gain_r, db_r, gap_r, step_r, fly_top_r;
  logic [15:0] feed_to_r;
  logic        rev_mode, rev_latch, fly_on, fly_latch, intake_latch;
  logic        feeder_on, feeder_latch;
  logic signed [7:0] right_cmd, left_cmd;
  logic [6:0]  fly_speed;
  logic [1:0]  intake_mode;
  logic [15:0] feeder_ticks;

  tick_t tick_q[$];
  cmd_t  cmd_q[$];
  tick_t drv_word;
  logic [7:0] btn_held = '0;
  bit    in_fire = 1'b0;
  bit    calm = 1'b0;
  int    sent_cnt = 0, acc_cnt = 0, chk_cnt = 0, cfg_cnt = 0, err_cnt = 0, cyc = 0;

  function automatic int clamp127(int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic int scale_stick(logic signed [7:0] s);
    int p;
    p = int'(s) * int'(gain_r);
    return clamp127(p / 100);
  endfunction

  function automatic logic signed [7:0] slew_to(int tgt, logic signed [7:0] cmd);
    int c, r, db;
    c  = int'(cmd);
    db = int'(db_r);
    if (tgt > db || tgt < -db) begin
      if (tgt - c > int'(gap_r) && tgt > 0) r = clamp127(c + int'(step_r));
      else if (tgt - c < -int'(gap_r) && tgt < 0) r = clamp127(c - int'(step_r));
      else r = tgt;
    end else begin
      r = 0;
    end
    return r[7:0];
  endfunction

  function automatic void mapper_reset();
    gain_r = RST_DRIVE_GAIN;
    db_r = RST_DRIVE_DEADBAND;
    gap_r = RST_SLEW_GAP;
    step_r = RST_SLEW_STEP;
    fly_top_r = RST_FLYWHEEL_TOP;
    feed_to_r = RST_FEEDER_TIMEOUT;
    rev_mode = 1'b1;
    rev_latch = 1'b0;
    right_cmd = '0;
    left_cmd = '0;
    fly_on = 1'b0;
    fly_latch = 1'b0;
    fly_speed = '0;
    intake_mode = INTAKE_OFF;
    intake_latch = 1'b0;
    feeder_on = 1'b0;
    feeder_latch = 1'b0;
    feeder_ticks = '0;
  endfunction

  function automatic cmd_t map_tick(tick_t t);
    int rt, lt;
    cmd_t o;
    if (t.rev && !rev_latch) begin
      rev_mode = !rev_mode;
      rev_latch = 1'b1;
    end
    if (!t.rev) rev_latch = 1'b0;
    if (!rev_mode) begin
      lt = scale_stick(t.sa);
      rt = scale_stick(t.sb);
    end else begin
      rt = -scale_stick(t.sa);
      lt = -scale_stick(t.sb);
    end
    right_cmd = slew_to(rt, right_cmd);
    left_cmd = slew_to(lt, left_cmd);

    if (t.fly1 && t.fly2 && !fly_latch) begin
      fly_on = !fly_on;
      fly_latch = 1'b1;
    end
    if (!t.fly1 && !t.fly2) fly_latch = 1'b0;
    if (fly_on && fly_speed < fly_top_r) fly_speed = fly_speed + 7'd1;
    else if (!fly_on && fly_speed != 7'd0) fly_speed = fly_speed - 7'd1;

    if (t.in_fwd && !intake_latch) begin
      intake_mode = intake_mode + 2'd1;
      intake_latch = 1'b1;
    end else if (t.in_rev && !intake_latch) begin
      intake_mode = intake_mode - 2'd1;
      intake_latch = 1'b1;
    end
    if (intake_mode == INTAKE_WRAP) intake_mode = INTAKE_OFF;
    if (!t.in_fwd && !t.in_rev) intake_latch = 1'b0;

    if (t.feed && !feeder_latch) begin
      feeder_on = !feeder_on;
      feeder_latch = 1'b1;
    end
    if (!t.feed) feeder_latch = 1'b0;
    feeder_ticks = feeder_on ? feeder_ticks + 16'd1 : 16'd0;
    if (feeder_ticks == feed_to_r) feeder_on = 1'b0;

    o.right = right_cmd;
    o.left = left_cmd;
    o.fly_pos = fly_speed;
    o.fly_neg = 8'd0 - {1'b0, fly_speed};
    case (intake_mode)
      INTAKE_FWD: o.intake = INTAKE_FWD_DRIVE;
      INTAKE_REV: o.intake = INTAKE_REV_DRIVE;
      default:    o.intake = 8'sd0;
    endcase
    o.feeder = feeder_on ? FEEDER_DRIVE : 7'd0;
    o.arm = t.arm_up ? ARM_UP_DRIVE : (t.arm_dn ? ARM_DOWN_DRIVE : 8'sd0);
    return o;
  endfunction

  function automatic tick_t mk(int sa, int sb, logic [7:0] btn);
    return tick_t'({8'(sa), 8'(sb), btn});
  endfunction

  function automatic logic signed [7:0] rand_stick();
    logic signed [7:0] v;
    case ($urandom_range(0, 3))
      0: v = 8'($urandom);
      1: begin
        if ($urandom_range(0, 1) != 0) v = 8'sd127 - 8'($urandom_range(0, 3));
        else v = -8'sd128 + 8'($urandom_range(0, 3));
      end
      2: begin
        v = 8'($urandom_range(0, 60));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = 8'sd0;
    endcase
    return v;
  endfunction

  // mostly press/hold/release sequences, some noise
  function automatic tick_t rand_tick(logic [7:0] keep);
    logic [7:0] flip;
    if ($urandom_range(0, 99) < 85) begin
      flip = '0;
      for (int i = 0; i < 8; i++) if ($urandom_range(0, 4) == 0) flip[i] = 1'b1;
      btn_held = btn_held ^ flip;
    end else begin
      btn_held = 8'($urandom);
    end
    btn_held = btn_held & keep;
    return mk(int'(rand_stick()), int'(rand_stick()), btn_held);
  endfunction

  task automatic queue_tick(tick_t t);
    tick_q.push_back(t);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (acc_cnt != sent_cnt || chk_cnt != acc_cnt);
    repeat (4) @(negedge clk);
  endtask

  // called at a falling edge with the block idle
  task automatic write_regs(int gain, int db, int gap, int step, int top, int tmo);
    logic [CFG_INDEX_W-1:0] idx [6];
    int vals [6];
    int want;
    idx[0] = REG_DRIVE_GAIN;
    idx[1] = REG_DRIVE_DEADBAND;
    idx[2] = REG_SLEW_GAP;
    idx[3] = REG_SLEW_STEP;
    idx[4] = REG_FLYWHEEL_TOP;
    idx[5] = REG_FEEDER_TIMEOUT;
    vals = '{gain, db, gap, step, top, tmo};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      want = cfg_cnt + 1;
      cfg_index <= idx[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      do @(negedge clk); while (cfg_cnt != want);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic report(string what, cmd_t want, cmd_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: exp r=%0d l=%0d fp=%0d fn=%0d in=%0d fe=%0d arm=%0d | got r=%0d l=%0d fp=%0d fn=%0d in=%0d fe=%0d arm=%0d",
               what, want.right, want.left, want.fly_pos, want.fly_neg, want.intake,
               want.feeder, want.arm, got.right, got.left, got.fly_pos, got.fly_neg,
               got.intake, got.feeder, got.arm);
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        drv_word = tick_q.pop_front();
        stick_a <= drv_word.sa;
        stick_b <= drv_word.sb;
        reverse_button <= drv_word.rev;
        fly_button_one <= drv_word.fly1;
        fly_button_two <= drv_word.fly2;
        intake_fwd_button <= drv_word.in_fwd;
        intake_rev_button <= drv_word.in_rev;
        feeder_button <= drv_word.feed;
        arm_up_button <= drv_word.arm_up;
        arm_down_button <= drv_word.arm_dn;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // predictor and scoreboard
  always @(posedge clk) begin
    cmd_t got;
    cmd_t want;
    in_fire <= in_valid && !in_stall && !rst;
    cyc++;
    if (cyc > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else if (rst) begin
      mapper_reset();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRIVE_GAIN:     gain_r = cfg_data[6:0];
          REG_DRIVE_DEADBAND: db_r = cfg_data[6:0];
          REG_SLEW_GAP:       gap_r = cfg_data[6:0];
          REG_SLEW_STEP:      step_r = cfg_data[6:0];
          REG_FLYWHEEL_TOP:   fly_top_r = cfg_data[6:0];
          REG_FEEDER_TIMEOUT: feed_to_r = cfg_data;
          default: ;
        endcase
        cfg_cnt++;
      end
      if (in_valid && !in_stall) begin
        cmd_q.push_back(map_tick(mk(int'(stick_a), int'(stick_b),
          {arm_down_button, arm_up_button, feeder_button, intake_rev_button,
           intake_fwd_button, fly_button_two, fly_button_one, reverse_button})));
        acc_cnt++;
      end
      if (out_valid && !out_stall) begin
        got = '{right_drive, left_drive, flywheel_pos, flywheel_neg, intake_drive,
                feeder_drive, arm_drive};
        if (cmd_q.size() == 0) begin
          report("unexpected word", '0, got);
        end else begin
          want = cmd_q.pop_front();
          if (got.right !== want.right || got.left !== want.left ||
              got.fly_pos !== want.fly_pos || got.fly_neg !== want.fly_neg ||
              got.intake !== want.intake || got.feeder !== want.feeder ||
              got.arm !== want.arm)
            report("field", want, got);
        end
        chk_cnt++;
      end
    end
  end

  initial begin : stim
    int gain, tmo;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset settings
    queue_tick(mk(0, 0, 8'h00));
    queue_tick(mk(127, -127, B_FLY1));
    queue_tick(mk(127, -127, B_FLY1 | B_FLY2 | B_IN_FWD));
    queue_tick(mk(127, -127, B_FLY1 | B_FLY2 | B_IN_FWD | B_IN_REV));
    queue_tick(mk(-128, 127, B_REV | B_IN_REV));
    queue_tick(mk(-128, 127, B_REV | B_FEED));
    queue_tick(mk(40, -40, B_IN_FWD | B_IN_REV | B_ARM_UP | B_ARM_DN));
    queue_tick(mk(25, -26, B_ARM_DN));
    queue_tick(mk(-1, 1, B_IN_REV | B_FEED));
    queue_tick(mk(0, 0, 8'h00));
    queue_tick(mk(0, 0, B_IN_REV));
    queue_tick(mk(-127, 127, B_FLY1 | B_FLY2));
    wait_drained();

    // directed, overflow settings
    write_regs(127, 0, 0, 127, 127, 2);
    queue_tick(mk(127, -128, 8'h00));
    queue_tick(mk(-128, 127, 8'h00));
    queue_tick(mk(-128, 127, 8'h00));
    queue_tick(mk(-128, 127, B_FEED));
    queue_tick(mk(1, -1, 8'h00));
    queue_tick(mk(0, 0, B_FEED));
    queue_tick(mk(0, 0, 8'h00));
    queue_tick(mk(0, 0, 8'h00));
    queue_tick(mk(127, 127, B_REV));
    queue_tick(mk(-127, -127, 8'h00));
    queue_tick(mk(100, -100, B_ARM_UP));
    queue_tick(mk(-100, 100, B_ARM_DN));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_regs(0, 0, 0, 1, 0, 1);
        1: write_regs(127, 127, 127, 127, 127, 65535);
        2: write_regs(63, 25, 20, 10, 90, 10000);
        3: write_regs(100, 0, 0, 127, 127, 3);
        default: begin
          gain = ($urandom_range(0, 3) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
          tmo = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
          write_regs(gain, $urandom_range(0, 60), $urandom_range(0, 127),
                     $urandom_range(1, 127), $urandom_range(0, 127), tmo);
        end
      endcase
      @(posedge clk);
      repeat (170) queue_tick(rand_tick(8'hFF));
      wait_drained();
    end

    // flywheel at full speed, then ceiling lowered below it
    write_regs(63, 25, 20, 10, 127, 10000);
    queue_tick(mk(0, 0, 8'h00));
    wait_drained();
    if (!fly_on) queue_tick(mk(0, 0, B_FLY1 | B_FLY2));
    repeat (140) queue_tick(rand_tick(~(B_FLY1 | B_FLY2)));
    wait_drained();
    write_regs(63, 25, 20, 10, 20, 10000);
    @(posedge clk);
    repeat (30) queue_tick(rand_tick(~(B_FLY1 | B_FLY2)));
    wait_drained();

    // feeder timeout, no idling
    write_regs(80, 10, 15, 25, 60, 40);
    queue_tick(mk(0, 0, 8'h00));
    wait_drained();
    calm = 1'b1;
    if (!feeder_on) queue_tick(mk(0, 0, B_FEED));
    repeat (100) queue_tick(rand_tick(~B_FEED));
    wait_drained();
    calm = 1'b0;

    repeat (10) @(negedge clk);
    $display("run covered %0d input words, %0d checked results, %0d register writes",
             acc_cnt, chk_cnt, cfg_cnt);
    $display("incl. saturation, deadband/slew corners, flywheel ceiling and feeder timeout");
    if (err_cnt == 0 && cmd_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
